// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the ranked signal list.
// Each macro expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, held off while reset is high.
`define RSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define RSL_NEVER(label, cond, msg) \
  `RSL_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/rsl_pkg.sv -----
// Package for the ranked signal list: item types, op codes, defaults and
// the dBm to quality conversion. No dependencies.
package rsl_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic signed [7:0] DBM_FLOOR = -8'sd100;
  localparam logic signed [7:0] DBM_CEIL  = -8'sd50;
  localparam logic [6:0]        QUAL_MAX  = 7'd100;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [7:0] signal_dbm;
    logic [15:0]       entry_tag;
    logic [3:0]        read_index;
  } req_item_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  position;
    logic [4:0]  list_count;
    logic        read_valid;
    logic [15:0] read_tag;
    logic [6:0]  read_quality;
  } rsp_item_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [6:0]  quality;
  } entry_t;

  // Insert command broadcast to every cell.
  typedef struct packed {
    logic   en;
    entry_t entry;
  } ins_cmd_t;

  function automatic logic [6:0] dbm_to_quality(input logic signed [7:0] dbm);
    logic signed [8:0] offs;
    logic [6:0]        q;
    offs = 9'(dbm) + 9'sd100;
    if (dbm <= DBM_FLOOR) begin
      q = '0;
    end else if (dbm >= DBM_CEIL) begin
      q = QUAL_MAX;
    end else begin
      q = {offs[5:0], 1'b0};
    end
    return q;
  endfunction

endpackage

// ----- rtl/ranked_signal_list_top.sv -----
// Ranked signal list: a row of rsl_cell slots kept sorted by quality,
// highest first, with an entry count and a registered result. Uses rsl_pkg.
//
// Usage: one request channel (req_valid, req_stall, req) and one result
// channel (rsp_valid, rsp_stall, rsp). Every accepted request gives exactly
// one result item. Ops: clear, insert (dBm converted to a 0..100 quality),
// read at an index, and a no-op that reports the count only.
// The result is registered on the edge that takes the request. Throughput
// is one item per cycle while the receiver does not stall; an insert
// compares and shifts all cells in parallel. The next request is taken
// while the result register is free or is being drained in the same cycle.
// When the receiver stalls, the result holds and req_stall rises until it
// is taken. Reset empties the list and drops any pending result; slot
// contents are left as they are and become readable only once written.
module ranked_signal_list_top #(
  parameter int unsigned MAX_ENTRIES = rsl_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  rsl_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsl_pkg::rsp_item_t rsp
);

  `include "assert_macros.svh"

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic                   take;
  logic [6:0]             new_quality;
  rsl_pkg::ins_cmd_t      ins;
  logic [MAX_ENTRIES-1:0] weaker;
  logic [MAX_ENTRIES-1:0] left_weaker;
  logic [MAX_ENTRIES-1:0] boundary;
  rsl_pkg::entry_t        cell_entry [MAX_ENTRIES];
  rsl_pkg::entry_t        left_entry [MAX_ENTRIES];
  logic [IW-1:0]          ins_pos;
  logic                   ins_ok;
  logic                   grow;
  logic                   rd_hit;
  rsl_pkg::entry_t        rd_entry;
  logic [CW+3:0]          count_ext;
  logic [IW+3:0]          pos_ext;
  rsl_pkg::rsp_item_t     rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign take      = req_valid && !req_stall;

  assign new_quality     = rsl_pkg::dbm_to_quality(req.signal_dbm);
  assign ins.en          = take && (req.op == rsl_pkg::OP_INSERT) && (new_quality != '0);
  assign ins.entry.tag     = req.entry_tag;
  assign ins.entry.quality = new_quality;

  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign left_weaker[j] = 1'b0;
      assign left_entry[j]  = ins.entry;
    end else begin : g_body
      assign left_weaker[j] = weaker[j-1];
      assign left_entry[j]  = cell_entry[j-1];
    end

    rsl_cell u_cell (
      .clk         (clk),
      .ins         (ins),
      .occupied    (CW'(j) < count),
      .left_weaker (left_weaker[j]),
      .left_entry  (left_entry[j]),
      .weaker      (weaker[j]),
      .entry       (cell_entry[j])
    );

    assign boundary[j] = weaker[j] && !left_weaker[j];
  end

  assign ins_ok = ins.en && (|weaker);
  assign grow   = ins_ok && (count != CW'(MAX_ENTRIES));

  // Boundary is one-hot at most, so OR the matching index together.
  always_comb begin
    ins_pos = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (boundary[j]) begin
        ins_pos = ins_pos | IW'(j);
      end
    end
  end

  assign rd_hit = {{4{1'b0}}, count} > {{CW{1'b0}}, req.read_index};

  always_comb begin
    rd_entry = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if ({{CW{1'b0}}, req.read_index} == (CW+4)'(j)) begin
        rd_entry = cell_entry[j];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (take) begin
      unique case (req.op) inside
        rsl_pkg::OP_CLEAR: begin
          count_next = '0;
        end
        rsl_pkg::OP_INSERT: begin
          if (grow) begin
            count_next = count + 1'b1;
          end
        end
        rsl_pkg::OP_READ, rsl_pkg::OP_NOP: begin
          count_next = count;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  assign count_ext = {{4{1'b0}}, count_next};
  assign pos_ext   = {{4{1'b0}}, ins_pos};

  always_comb begin
    rsp_next            = '0;
    rsp_next.list_count = count_ext[4:0];
    if (req.op == rsl_pkg::OP_INSERT && ins_ok) begin
      rsp_next.accepted = 1'b1;
      rsp_next.position = pos_ext[3:0];
    end
    if (req.op == rsl_pkg::OP_READ && rd_hit) begin
      rsp_next.read_valid   = 1'b1;
      rsp_next.read_tag     = rd_entry.tag;
      rsp_next.read_quality = rd_entry.quality;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= rsp_next;
    end
  end

  `RSL_NEVER(a_count_bound, count > CW'(MAX_ENTRIES), "entry count above capacity")
  `RSL_ASSERT(a_single_slot, $onehot0(boundary), "more than one insert slot")
  `RSL_ASSERT(a_take_gives_rsp, take |=> rsp_valid, "accepted item gave no result")
  `RSL_ASSERT(a_count_grows, grow |=> count == $past(count) + 1'b1, "insert did not grow count")
  `RSL_NEVER(a_nop_no_ins, ins.en && req.op != rsl_pkg::OP_INSERT, "insert enabled on other op")

endmodule

// ----- rtl/rsl_cell.sv -----
// One slot of the sorted list: holds an entry and decides on insert whether
// to keep it, take the new entry or take its left neighbor. Uses rsl_pkg.
module rsl_cell (
  input  logic              clk,
  input  rsl_pkg::ins_cmd_t ins,
  input  logic              occupied,
  input  logic              left_weaker,
  input  rsl_pkg::entry_t   left_entry,
  output logic              weaker,
  output rsl_pkg::entry_t   entry
);

  // Empty slots count as weaker so the new item lands at the tail.
  assign weaker = !(occupied && (entry.quality >= ins.entry.quality));

  always_ff @(posedge clk) begin
    if (ins.en && weaker) begin
      entry <= left_weaker ? left_entry : ins.entry;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench for ranked_signal_list_top. Sends clear, insert, read and no-op
// requests and checks every result against a sorted-list predictor kept here.
// Depends on rsl_pkg and ranked_signal_list_top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS      = rsl_pkg::MAX_ENTRIES_DEF;
  localparam int RANDOM_ITEMS   = 650;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int LONG_HOLD      = 60;
  localparam int HOLD_AT_RESULT = 120;
  localparam int DRAIN_CYCLES   = 10;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  rsl_pkg::req_item_t req       = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rsl_pkg::rsp_item_t rsp;

  rsl_pkg::req_item_t pending_reqs[$];
  rsl_pkg::rsp_item_t results_due[$];
  rsl_pkg::rsp_item_t oldest_due;
  logic [15:0] slot_tag [NUM_SLOTS];
  logic [6:0]  slot_qual [NUM_SLOTS];
  int          entry_count = 0;
  int          errors      = 0;
  int          sent        = 0;
  int          taken       = 0;
  int          send_gap    = 0;
  int          hold_left   = 0;
  int          cycles      = 0;
  logic        next_valid;

  ranked_signal_list_top #(.MAX_ENTRIES(NUM_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic rsl_pkg::req_item_t make_item(logic [1:0] op, logic signed [7:0] dbm,
                                                   logic [15:0] tag, logic [3:0] idx);
    rsl_pkg::req_item_t item;
    item.op         = op;
    item.signal_dbm = dbm;
    item.entry_tag  = tag;
    item.read_index = idx;
    return item;
  endfunction

  function automatic logic [6:0] quality_for(logic signed [7:0] dbm);
    int d;
    d = dbm;
    if (dbm <= rsl_pkg::DBM_FLOOR) return 7'd0;
    if (dbm >= rsl_pkg::DBM_CEIL) return rsl_pkg::QUAL_MAX;
    return 7'(2 * (d + 100));
  endfunction

  // Apply one request to the local copy of the list and return its result.
  function automatic rsl_pkg::rsp_item_t predict_list_result(rsl_pkg::req_item_t item);
    rsl_pkg::rsp_item_t r;
    logic [6:0]         q;
    int                 pos;
    int                 j;
    r = '0;
    case (item.op)
      rsl_pkg::OP_CLEAR: entry_count = 0;
      rsl_pkg::OP_INSERT: begin
        q = quality_for(item.signal_dbm);
        if (q != 0) begin
          pos = 0;
          while (pos < entry_count && slot_qual[pos] >= q) pos++;
          if (pos < NUM_SLOTS) begin
            // shift weaker entries down; the last one falls off a full list
            j = (entry_count < NUM_SLOTS) ? entry_count : NUM_SLOTS - 1;
            while (j > pos) begin
              slot_tag[j]  = slot_tag[j - 1];
              slot_qual[j] = slot_qual[j - 1];
              j--;
            end
            slot_tag[pos]  = item.entry_tag;
            slot_qual[pos] = q;
            if (entry_count < NUM_SLOTS) entry_count++;
            r.accepted = 1'b1;
            r.position = 4'(pos);
          end
        end
      end
      rsl_pkg::OP_READ: begin
        if (item.read_index < entry_count) begin
          r.read_valid   = 1'b1;
          r.read_tag     = slot_tag[item.read_index];
          r.read_quality = slot_qual[item.read_index];
        end
      end
      rsl_pkg::OP_NOP: ;
    endcase
    r.list_count = 5'(entry_count);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Request driver: offer queued items with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
      send_gap  = 0;
    end else begin
      next_valid = req_valid;
      if (req_valid && !req_stall) begin
        results_due.push_back(predict_list_result(req));
        sent++;
        next_valid = 1'b0;
        // hold a stretch of back-to-back items in the middle of the run
        send_gap = (sent >= 200 && sent < 300) ? 0 : $urandom_range(0, 5);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          next_valid = 1'b1;
        end
      end
      req_valid <= next_valid;
    end
  end

  // Result monitor: take results with random stalls and check each one.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        taken++;
        if (results_due.size() == 0) begin
          $error("result item arrived with nothing expected");
          errors++;
        end else begin
          oldest_due = results_due.pop_front();
          check_field("accepted", oldest_due.accepted, rsp.accepted);
          check_field("position", oldest_due.position, rsp.position);
          check_field("list_count", oldest_due.list_count, rsp.list_count);
          check_field("read_valid", oldest_due.read_valid, rsp.read_valid);
          check_field("read_tag", oldest_due.read_tag, rsp.read_tag);
          check_field("read_quality", oldest_due.read_quality, rsp.read_quality);
        end
        hold_left = (taken >= 350 && taken < 450) ? 0 : $urandom_range(0, 5);
        // long hold so the block fills up and stalls its input
        if (taken == HOLD_AT_RESULT) hold_left = LONG_HOLD;
      end
      rsp_stall <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int                pick;
    int                d;
    logic signed [7:0] dbm;
    logic [1:0]        op;

    // directed: empty list, refused and clamped qualities, ties, range edges
    pending_reqs.push_back(make_item(rsl_pkg::OP_CLEAR, 8'sd0, 16'h0000, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_READ, 8'sd0, 16'h0000, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_INSERT, -8'sd128, 16'hFFFF, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_INSERT, -8'sd100, 16'h0011, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_INSERT, -8'sd99, 16'h0001, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_INSERT, -8'sd50, 16'h0002, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_INSERT, 8'sd127, 16'h0003, 4'd15));
    pending_reqs.push_back(make_item(rsl_pkg::OP_INSERT, -8'sd51, 16'h0000, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_INSERT, -8'sd75, 16'hFFFF, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_INSERT, -8'sd75, 16'h0005, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_READ, 8'sd0, 16'h0000, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_READ, 8'sd0, 16'h0000, 4'd1));
    pending_reqs.push_back(make_item(rsl_pkg::OP_READ, 8'sd0, 16'h0000, 4'd5));
    pending_reqs.push_back(make_item(rsl_pkg::OP_READ, 8'sd0, 16'h0000, 4'd6));
    pending_reqs.push_back(make_item(rsl_pkg::OP_READ, -8'sd128, 16'hFFFF, 4'd15));
    pending_reqs.push_back(make_item(rsl_pkg::OP_NOP, 8'sd127, 16'hFFFF, 4'd15));
    pending_reqs.push_back(make_item(rsl_pkg::OP_CLEAR, -8'sd128, 16'hFFFF, 4'd15));
    pending_reqs.push_back(make_item(rsl_pkg::OP_READ, 8'sd0, 16'h0000, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_INSERT, -8'sd99, 16'h0007, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_READ, 8'sd0, 16'h0000, 4'd0));
    pending_reqs.push_back(make_item(rsl_pkg::OP_NOP, 8'sd0, 16'h0000, 4'd0));

    // random: mostly inserts and reads, rare clears so the list runs full
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) op = rsl_pkg::OP_CLEAR;
      else if (pick < 58) op = rsl_pkg::OP_INSERT;
      else if (pick < 92) op = rsl_pkg::OP_READ;
      else op = rsl_pkg::OP_NOP;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        d = int'($urandom_range(0, 48)) - 99;
        dbm = 8'(d);
      end else if (pick < 8) begin
        dbm = 8'($urandom_range(0, 255));
      end else begin
        // few distinct levels to force ties
        d = -60 - 10 * int'($urandom_range(0, 3));
        dbm = 8'(d);
      end
      pending_reqs.push_back(make_item(op, dbm, 16'($urandom_range(0, 65535)),
                                       4'($urandom_range(0, 15))));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
